[sv/sts_pkg.sv]
package sts_pkg;

	localparam int KEY_W = 64;
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_SEARCH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CMP_LT = 2'd0,
		CMP_EQ = 2'd1,
		CMP_GT = 2'd2
	} cmp_t;

endpackage

[sv/sts_key_ram.sv]
module sts_key_ram
	import sts_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/sts_cmp.sv]
module sts_cmp
	import sts_pkg::*;
(
	input  logic [KEY_W-1:0] key_a,
	input  logic [KEY_W-1:0] key_b,
	output cmp_t             result
);

	// Signed compare of the probe key against the entry read from the table.
	always_comb begin
		priority if ($signed(key_a) > $signed(key_b)) begin
			result = CMP_GT;
		end else if ($signed(key_a) < $signed(key_b)) begin
			result = CMP_LT;
		end else begin
			result = CMP_EQ;
		end
	end

endmodule

[sv/sts_search.sv]
module sts_search
	import sts_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW = 10,
	parameter int CW = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [KEY_W-1:0]   key,
	input  logic [COUNT_W-1:0] entry_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [COUNT_W-1:0] position,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	output logic [KEY_W-1:0]   probe_key,
	input  cmp_t               cmp_res
);

	localparam int CWP = CW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SRCH,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [KEY_W-1:0]   key_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [AW-1:0]      mid_q;
	logic               found_q;
	logic [COUNT_W-1:0] pos_q;
	logic               out_valid_q;
	logic               found_out_q;
	logic [COUNT_W-1:0] position_q;

	logic [CW-1:0] cnt;
	logic [AW-1:0] mid_start;
	logic [CW-1:0] lo_n;
	logic [CW-1:0] hi_n;
	logic [AW-1:0] mid_n;
	logic          more;
	logic          start;

	assign in_ready = (state_q == ST_IDLE);
	assign start = in_valid && in_ready && (action == ACT_SEARCH);
	assign out_valid = out_valid_q;
	assign found = found_out_q;
	assign position = position_q;
	assign probe_key = key_q;

	always_comb begin
		if (32'(entry_count) > DEPTH) begin
			cnt = CW'(DEPTH);
		end else begin
			cnt = CW'(entry_count);
		end
		mid_start = AW'((CWP'(cnt) - CWP'(1)) >> 1);
	end

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		unique case (cmp_res)
			CMP_GT: begin
				lo_n = CW'(mid_q) + CW'(1);
			end
			CMP_LT: begin
				hi_n = CW'(mid_q);
			end
			default: begin
			end
		endcase
		more = (lo_n < hi_n);
		mid_n = AW'((CWP'(lo_n) + CWP'(hi_n) - CWP'(1)) >> 1);
	end

	always_comb begin
		ram_we = in_valid && in_ready && (action == ACT_WRITE) && (32'(entry_index) < DEPTH);
		ram_waddr = AW'(entry_index);
		if (state_q == ST_IDLE) begin
			ram_raddr = mid_start;
			ram_re = start && (cnt != '0);
		end else begin
			ram_raddr = mid_n;
			ram_re = (state_q == ST_SRCH) && (cmp_res != CMP_EQ) && more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q <= key;
						lo_q <= '0;
						hi_q <= cnt;
						mid_q <= mid_start;
						if (cnt == '0) begin
							found_q <= 1'b0;
							pos_q <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (cmp_res == CMP_EQ) begin
						found_q <= 1'b1;
						pos_q <= COUNT_W'(mid_q);
						state_q <= ST_FIN;
					end else begin
						lo_q <= lo_n;
						hi_q <= hi_n;
						mid_q <= mid_n;
						if (!more) begin
							found_q <= 1'b0;
							pos_q <= COUNT_W'(lo_n);
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_out_q <= found_q;
						position_q <= pos_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/sorted_table_binary_search.sv]
// Channel   Handshake                    Payload
// input     in_valid / in_ready          action, entry_index, key
// output    out_valid / out_ready        found, position
// config    cfg_we                       cfg_wdata (entry_count)
//
// A write beat leaves the block ready, since it never starts the sequencer.
// A search beat starts from idle, runs its probes in the search state, and
// then the finish state loads the output register.
// Each probe is one table read plus one 64-bit compare, issued back to back.
// Reset clears the control state and entry_count; the key table is not cleared.
// A stalled output holds the finished search in the sequencer until it drains.
module sorted_table_binary_search
	import sts_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [KEY_W-1:0]   key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [COUNT_W-1:0] position
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [COUNT_W-1:0] entry_count_q;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [KEY_W-1:0]   ram_rdata;
	logic [KEY_W-1:0]   probe_key;
	cmp_t               cmp_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	sts_key_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(key),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sts_cmp u_cmp (
		.key_a(probe_key),
		.key_b(ram_rdata),
		.result(cmp_res)
	);

	sts_search #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_search (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.entry_index(entry_index),
		.key(key),
		.entry_count(entry_count_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.position(position),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.probe_key(probe_key),
		.cmp_res(cmp_res)
	);

	// A write beat never starts a search.
	a_write_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_WRITE) |=> in_ready)
		else $error("write beat left the block busy");

	// A search beat always occupies the sequencer, so in_ready drops after it is taken.
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_SEARCH) |=> !in_ready)
		else $error("search beat did not start the sequencer");

	// A hit always lies inside the searched entries.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (position < entry_count_q))
		else $error("hit position beyond entry count");

	// An insertion point never lies past the searched entries.
	a_miss_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (position <= entry_count_q))
		else $error("insertion point beyond entry count");

endmodule

[dv/tb_sorted_table_binary_search.sv]
import sts_pkg::*;

typedef struct {
	logic               found;
	logic [COUNT_W-1:0] position;
} lookup_result_t;

class search_scoreboard;
	localparam int DEPTH = 1024;

	logic signed [KEY_W-1:0] keys [DEPTH];
	logic [COUNT_W-1:0]      count_setting;
	lookup_result_t          expected_q [$];
	int                      mismatches;

	function new();
		count_setting = '0;
		mismatches = 0;
	endfunction

	function void set_count(logic [COUNT_W-1:0] value);
		count_setting = value;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void note_beat(action_t act, logic [INDEX_W-1:0] idx, logic signed [KEY_W-1:0] k);
		int             first_i;
		int             last_i;
		int             mid;
		int             limit;
		bit             hit;
		lookup_result_t res;
		if (act == ACT_WRITE) begin
			if (idx < DEPTH)
				keys[idx] = k;
			return;
		end
		limit = (count_setting > DEPTH) ? DEPTH : int'(count_setting);
		first_i = 0;
		last_i = limit - 1;
		mid = 0;
		hit = 1'b0;
		while (first_i <= last_i && !hit) begin
			mid = (first_i + last_i) / 2;
			if (k > keys[mid])
				first_i = mid + 1;
			else if (k < keys[mid])
				last_i = mid - 1;
			else
				hit = 1'b1;
		end
		res.found = hit;
		res.position = hit ? mid[COUNT_W-1:0] : first_i[COUNT_W-1:0];
		expected_q.insert(expected_q.size(), res);
	endfunction

	function void check_result(logic f, logic [COUNT_W-1:0] pos);
		lookup_result_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: found=%0b position=%0d", f, pos);
			return;
		end
		e = expected_q.pop_front();
		if (f !== e.found || pos !== e.position) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
					e.found, e.position, f, pos);
		end
	endfunction
endclass

module tb_sorted_table_binary_search;

	localparam int TABLE_DEPTH = 1024;
	localparam int SETTLE = 16;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	action_t            action;
	logic [INDEX_W-1:0] entry_index;
	logic [KEY_W-1:0]   key;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [COUNT_W-1:0] position;

	search_scoreboard sb = new();
	int burst_left = 1;

	sorted_table_binary_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.entry_index(entry_index),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.position(position)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 500000);
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(action_t a, logic [INDEX_W-1:0] idx, logic [KEY_W-1:0] k);
		in_valid <= 1'b1;
		action <= a;
		entry_index <= idx;
		key <= k;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(a, idx, k);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(logic [COUNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.set_count(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic search(logic [KEY_W-1:0] k);
		send_beat(ACT_SEARCH, INDEX_W'($urandom), k);
	endtask

	task automatic fill_table();
		logic signed [KEY_W-1:0] base;
		logic [KEY_W-1:0]        r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			base = longint'(i - 512) <<< 53;
			r = rand_key();
			send_beat(ACT_WRITE, INDEX_W'(i), base + {12'b0, r[51:0]});
		end
	endtask

	// Rewrites one entry with a key that lies between its neighbors, so the
	// table stays in ascending order unless it was already disturbed there.
	task automatic ordered_write();
		int                      idx;
		logic signed [KEY_W-1:0] lo;
		logic signed [KEY_W-1:0] hi;
		logic [KEY_W-1:0]        span;
		logic [KEY_W-1:0]        k;
		idx = $urandom_range(TABLE_DEPTH - 1);
		lo = (idx == 0) ? KEY_MIN : sb.keys[idx - 1];
		hi = (idx == TABLE_DEPTH - 1) ? KEY_MAX : sb.keys[idx + 1];
		if (lo > hi) begin
			k = rand_key();
		end else begin
			span = hi - lo;
			k = (span == '1) ? rand_key() : lo + (rand_key() % (span + 1));
		end
		send_beat(ACT_WRITE, INDEX_W'(idx), k);
	endtask

	function automatic logic [KEY_W-1:0] pick_search_key(int limit);
		int               r;
		int               j;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		j = (limit > 0) ? $urandom_range(limit - 1) : $urandom_range(TABLE_DEPTH - 1);
		if (r < 40)
			k = sb.keys[j];
		else if (r < 65)
			k = $urandom_range(1) ? sb.keys[j] + 1 : sb.keys[j] - 1;
		else if (r < 90)
			k = rand_key();
		else
			k = $urandom_range(1) ? KEY_MAX : KEY_MIN;
		return k;
	endfunction

	task automatic run_phase(int beats, bit noisy);
		int r;
		int limit;
		limit = (sb.count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.count_setting);
		for (int n = 0; n < beats; n++) begin
			r = $urandom_range(99);
			if (noisy && r < 5)
				send_beat(ACT_WRITE, INDEX_W'($urandom), rand_key());
			else if (r < 20)
				ordered_write();
			else
				search(pick_search_key(limit));
		end
	endtask

	initial begin
		logic signed [KEY_W-1:0] saved;
		int                      counts [10];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		action = ACT_WRITE;
		entry_index = '0;
		key = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_count('0);
		search(KEY_MIN);
		search(KEY_MAX);
		search('0);
		send_beat(ACT_WRITE, '0, KEY_MIN);
		send_beat(ACT_WRITE, '1, KEY_MAX);
		fill_table();

		write_count(COUNT_W'(1));
		search(KEY_MIN);
		search(KEY_MAX);
		search(sb.keys[0]);

		write_count('1);
		search(KEY_MAX);
		search(KEY_MIN);
		search(sb.keys[TABLE_DEPTH - 1]);
		search(sb.keys[511]);
		search(sb.keys[511] + 1);

		write_count(COUNT_W'(3));
		saved = sb.keys[1];
		send_beat(ACT_WRITE, INDEX_W'(1), sb.keys[0]);
		search(sb.keys[0]);
		send_beat(ACT_WRITE, INDEX_W'(1), KEY_MAX);
		search(sb.keys[2]);
		send_beat(ACT_WRITE, INDEX_W'(1), saved);

		counts = '{1024, 2047, 1, 2, 3, 8, 1023, 0, 100, 0};
		counts[9] = $urandom_range(4, 600);
		foreach (counts[p]) begin
			write_count(COUNT_W'(counts[p]));
			run_phase(95, p == 9);
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [31:0] cyc;
		int          seen;
		bit          held;
		cyc = '0;
		seen = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(found, position);
				seen++;
			end
			cyc++;
			// One long hold-off so the block backs up and stalls its input.
			if (!held && seen >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			case (cyc[9:8])
				2'd0: begin
					out_ready <= 1'b1;
				end
				2'd1: begin
					out_ready <= ($urandom_range(1) == 1);
				end
				2'd2: begin
					out_ready <= ($urandom_range(3) == 0);
				end
				default: begin
					out_ready <= (cyc[2:0] != 3'd5 && cyc[2:0] != 3'd6);
				end
			endcase
		end
	end

endmodule
